// File: rtl/core/integer_pixel_upscaler_core_defines.svh
// Assertion macros used by the checker file of the upscaler core.
`ifndef INTEGER_PIXEL_UPSCALER_CORE_DEFINES_SVH
`define INTEGER_PIXEL_UPSCALER_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define IPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define IPU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/ipu_pkg.sv
`timescale 1ns / 1ps

package ipu_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_SCALE  = 4;

    localparam int PIX_W       = 32;
    localparam int ADDR_W      = 28;
    localparam int SCALE_CFG_W = 3;
    localparam int WIDTH_CFG_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'd1;

    localparam logic [SCALE_CFG_W-1:0] SCALE_RESET = 3'd2;
    localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 13'd320;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted pixel and advance the position
        logic mul1;      // destination width, row and column products
        logic mul2;      // row base address product
        logic sum;       // first write address of the block
        logic next_col;  // step to the next write in the same line
        logic next_row;  // step to the first write of the next line
    } ipu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sc_last;
        logic sr_last;
    } ipu_status_t;

endpackage

// File: rtl/core/integer_pixel_upscaler_core.sv
`timescale 1ns / 1ps
// Nearest-neighbor integer upscaler core.
// Source pixels enter on the s_ channel in raster order, one transfer per pixel,
// with s_frame_start marking the first pixel of a frame, which resets the column
// and row position. For each pixel the core sends scale*scale transfers on the
// m_ channel, line by line within the replicated block, each holding the
// destination address, the unchanged pixel, and m_run_last on the final one.
// Scale and source width are written through the cfg_ port; the user must do so
// only while the core idles, as the core itself does not enforce it. Each pixel
// is accepted, then passes through address arithmetic (two multiplier stages and
// an add), then one write per cycle is sent while the receiver is ready. m_valid
// rises after the controller has stepped through the MUL1, MUL2 and SUM states.
// The output is registered, so a stalled receiver simply holds the current write
// steady on the m_ ports and the core waits; s_ready stays low until the last
// write of the pixel has been taken. Synchronous reset restores scale 2 and
// width 320, clears the position, and drops m_valid.

module integer_pixel_upscaler_core
    import ipu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel_value,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_W-1:0]     m_dest_address,
    output logic [PIX_W-1:0]      m_out_pixel,
    output logic                  m_run_last
);

    // The controller sequences each pixel; the datapath holds the position
    // counters, the configuration, and the address arithmetic.
    ipu_cmd_t    cmd;
    ipu_status_t status;

    ipu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ipu_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_pixel_value  (s_pixel_value),
        .s_frame_start  (s_frame_start),
        .m_dest_address (m_dest_address),
        .m_out_pixel    (m_out_pixel),
        .m_run_last     (m_run_last),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// File: rtl/core/ipu_ctrl.sv
`timescale 1ns / 1ps

module ipu_ctrl
    import ipu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  ipu_status_t status,
    output ipu_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_xfer;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_EMIT);
    assign out_xfer = m_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    priority if (status.sc_last && status.sr_last) begin
                        state_next = ST_IDLE;
                    end else if (status.sc_last) begin
                        cmd.next_row = 1'b1;
                    end else begin
                        cmd.next_col = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/ipu_datapath.sv
`timescale 1ns / 1ps

module ipu_datapath
    import ipu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PIX_W-1:0]      s_pixel_value,
    input  logic                  s_frame_start,
    output logic [ADDR_W-1:0]     m_dest_address,
    output logic [PIX_W-1:0]      m_out_pixel,
    output logic                  m_run_last,
    input  ipu_cmd_t              cmd,
    output ipu_status_t           status
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SW    = $clog2(MAX_SCALE + 1);
    localparam int DW_W  = WW + SW;
    localparam int RS_W  = ROW_W + SW;
    localparam int CS_W  = COL_W + SW;
    localparam int PR_W  = RS_W + DW_W;

    logic [SCALE_CFG_W-1:0] cfg_scale_reg;
    logic [WIDTH_CFG_W-1:0] cfg_width_reg;
    logic [COL_W-1:0]       col_reg;
    logic [ROW_W-1:0]       row_reg;

    logic [SW-1:0]     scale_reg;
    logic [WW-1:0]     width_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [PIX_W-1:0]  pixel_reg;
    logic [DW_W-1:0]   dest_w_reg;
    logic [RS_W-1:0]   rs_reg;
    logic [CS_W-1:0]   cs_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] line_reg;
    logic [SW-1:0]     sc_reg;
    logic [SW-1:0]     sr_reg;

    logic [SW-1:0]    s_eff;
    logic [WW-1:0]    w_eff;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic [PR_W-1:0]  row_prod;
    logic [ADDR_W-1:0] next_line;
    logic             sc_last;
    logic             sr_last;

    // Out-of-range settings are clamped into the supported range.
    always_comb begin
        if (cfg_scale_reg == '0) begin
            s_eff = SW'(1);
        end else if (32'(cfg_scale_reg) > 32'(MAX_SCALE)) begin
            s_eff = SW'(MAX_SCALE);
        end else begin
            s_eff = SW'(cfg_scale_reg);
        end
        if (cfg_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg_width_reg);
        end
    end

    assign cur_col   = s_frame_start ? '0 : col_reg;
    assign cur_row   = s_frame_start ? '0 : row_reg;
    assign col_inc   = {1'b0, cur_col} + 1'b1;
    assign row_inc   = {1'b0, cur_row} + 1'b1;
    assign row_prod  = PR_W'(rs_reg) * PR_W'(dest_w_reg);
    assign next_line = line_reg + ADDR_W'(dest_w_reg);

    assign sc_last = (SW'(sc_reg + 1'b1) == scale_reg);
    assign sr_last = (SW'(sr_reg + 1'b1) == scale_reg);
    assign status  = '{sc_last: sc_last, sr_last: sr_last};

    assign m_dest_address = addr_reg;
    assign m_out_pixel    = pixel_reg;
    assign m_run_last     = sc_last && sr_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_scale_reg <= SCALE_RESET;
            cfg_width_reg <= WIDTH_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_SCALE: cfg_scale_reg <= cfg_data[SCALE_CFG_W-1:0];
                    REG_WIDTH: cfg_width_reg <= cfg_data[WIDTH_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                if (32'(col_inc) >= 32'(w_eff)) begin
                    col_reg <= '0;
                    row_reg <= (32'(row_inc) >= 32'(MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    col_reg <= col_inc[COL_W-1:0];
                    row_reg <= cur_row;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            scale_reg   <= s_eff;
            width_reg   <= w_eff;
            cur_col_reg <= cur_col;
            cur_row_reg <= cur_row;
            pixel_reg   <= s_pixel_value;
        end
        if (cmd.mul1) begin
            dest_w_reg <= DW_W'(width_reg) * DW_W'(scale_reg);
            rs_reg     <= RS_W'(cur_row_reg) * RS_W'(scale_reg);
            cs_reg     <= CS_W'(cur_col_reg) * CS_W'(scale_reg);
        end
        if (cmd.mul2) begin
            base_reg <= ADDR_W'(row_prod);
        end
        if (cmd.sum) begin
            addr_reg <= base_reg + ADDR_W'(cs_reg);
            line_reg <= base_reg + ADDR_W'(cs_reg);
            sc_reg   <= '0;
            sr_reg   <= '0;
        end
        if (cmd.next_col) begin
            addr_reg <= addr_reg + 1'b1;
            sc_reg   <= sc_reg + 1'b1;
        end
        if (cmd.next_row) begin
            addr_reg <= next_line;
            line_reg <= next_line;
            sc_reg   <= '0;
            sr_reg   <= sr_reg + 1'b1;
        end
    end

endmodule

// File: rtl/core/ipu_checker.sv
`timescale 1ns / 1ps
`include "integer_pixel_upscaler_core_defines.svh"

module ipu_checker
    import ipu_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ADDR_W-1:0]     m_dest_address,
    input logic [PIX_W-1:0]      m_out_pixel,
    input logic                  m_run_last
);

    logic                    out_stall;
    logic                    out_xfer;
    logic [ADDR_W+PIX_W:0]   out_word;

    assign out_stall = m_valid && !m_ready;
    assign out_xfer  = m_valid && m_ready;
    assign out_word  = {m_dest_address, m_out_pixel, m_run_last};

    // A stalled write holds its contents.
    `IPU_ASSERT(a_out_hold, out_stall |=> m_valid && $stable(out_word), "stalled write changed")
    // No new pixel is taken while writes of the current one are pending.
    `IPU_ASSERT(a_no_overlap, m_valid |-> !s_ready, "input ready while writes pending")
    // A write that is not the last of its pixel is followed at once by another.
    `IPU_ASSERT(a_run_cont, out_xfer && !m_run_last |=> m_valid, "write run broken")
    // The last write ends the run.
    `IPU_ASSERT(a_run_end, out_xfer && m_run_last |=> !m_valid && s_ready, "run did not end")
    // Reset drops the output.
    `IPU_ASSERT_RST(a_reset, !aresetn |=> !m_valid, "write valid after reset")

endmodule

bind integer_pixel_upscaler_core ipu_checker u_ipu_checker (.*);
